FILE: design/obt_pkg.sv
package obt_pkg;

	// axis components, q1.14
	localparam int AXIS_BITS  = 16;
	localparam int AXIS_FRAC  = 14;
	localparam int ROUND_HALF = 1 << (AXIS_FRAC - 1);
	localparam logic signed [AXIS_BITS-1:0] AXIS_ONE = 16'sd16384;

	// growth of a projected sum over the coordinate width
	localparam int SUM_EXTRA = AXIS_BITS + 3;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_X   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_Y   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_COS = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_SIN = 3'd5;

	// commands
	localparam logic CMD_POINT = 1'b0;
	localparam logic CMD_BOX   = 1'b1;

	// corner order: bit set where that corner takes the negative half extent
	localparam logic [3:0] CORNER_XNEG = 4'b0101;
	localparam logic [3:0] CORNER_YNEG = 4'b1100;

	// pipeline shape
	localparam int NUM_STAGES = 7;
	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

FILE: design/obt_if.sv
interface obt_req_if #(parameter int COORD_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic [COORD_BITS-2:0]        query_half_w;
	logic [COORD_BITS-2:0]        query_half_h;

	modport source (output valid, command, query_x, query_y, query_half_w, query_half_h,
		input ready);
	modport sink (input valid, command, query_x, query_y, query_half_w, query_half_h,
		output ready);
endinterface

interface obt_rsp_if #(parameter int COORD_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic signed [COORD_BITS-1:0] nearest_x;
	logic signed [COORD_BITS-1:0] nearest_y;

	modport source (output valid, hit, nearest_x, nearest_y, input ready);
	modport sink (input valid, hit, nearest_x, nearest_y, output ready);
endinterface

FILE: design/obt_corners.sv
module obt_corners #(
	parameter int COORD_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [obt_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [COORD_BITS-1:0]                  cfg_data,
	output logic signed [COORD_BITS-1:0]           center_x,
	output logic signed [COORD_BITS-1:0]           center_y,
	output logic [COORD_BITS-2:0]                  half_x,
	output logic [COORD_BITS-2:0]                  half_y,
	output logic signed [obt_pkg::AXIS_BITS-1:0]   axis_cos,
	output logic signed [obt_pkg::AXIS_BITS-1:0]   axis_sin,
	output logic signed [COORD_BITS-1:0]           corner_x [4],
	output logic signed [COORD_BITS-1:0]           corner_y [4]
);
	import obt_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int PW = C + AXIS_BITS;
	localparam int OW = PW + 2;
	localparam int SW = OW - AXIS_FRAC + 1;

	logic signed [C-1:0]         center_x_q, center_y_q;
	logic [C-2:0]                half_x_q, half_y_q;
	logic signed [AXIS_BITS-1:0] axis_cos_q, axis_sin_q;
	logic signed [C-1:0]         hx_s, hy_s;
	logic signed [PW-1:0]        pcx_q, psx_q, pcy_q, psy_q;
	logic signed [C-1:0]         corner_x_d [4], corner_y_d [4];
	logic signed [C-1:0]         corner_x_q [4], corner_y_q [4];

	function automatic logic signed [C-1:0] sat_c(input logic signed [SW-1:0] v);
		logic signed [C-1:0] r;
		if (v[SW-1:C-1] == {(SW-C+1){1'b0}} || v[SW-1:C-1] == {(SW-C+1){1'b1}}) begin
			r = v[C-1:0];
		end else if (v[SW-1]) begin
			r = {1'b1, {(C-1){1'b0}}};
		end else begin
			r = {1'b0, {(C-1){1'b1}}};
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			half_x_q   <= '0;
			half_y_q   <= '0;
			axis_cos_q <= AXIS_ONE;
			axis_sin_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X: center_x_q <= cfg_data[C-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[C-1:0];
				REG_HALF_X:   half_x_q   <= cfg_data[C-2:0];
				REG_HALF_Y:   half_y_q   <= cfg_data[C-2:0];
				REG_AXIS_COS: axis_cos_q <= cfg_data[AXIS_BITS-1:0];
				REG_AXIS_SIN: axis_sin_q <= cfg_data[AXIS_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign hx_s = $signed({1'b0, half_x_q});
	assign hy_s = $signed({1'b0, half_y_q});

	// four distinct axis x half products, shared by all corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcx_q <= '0;
			psx_q <= '0;
			pcy_q <= '0;
			psy_q <= '0;
		end else begin
			pcx_q <= PW'(axis_cos_q) * PW'(hx_s);
			psx_q <= PW'(axis_sin_q) * PW'(hx_s);
			pcy_q <= PW'(axis_cos_q) * PW'(hy_s);
			psy_q <= PW'(axis_sin_q) * PW'(hy_s);
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_corner
		logic signed [OW-1:0] ta_x, tb_x, ta_y, tb_y, off_x, off_y;
		logic signed [SW-1:0] sum_x, sum_y;

		assign ta_x  = CORNER_XNEG[i] ? -OW'(pcx_q) : OW'(pcx_q);
		assign tb_x  = CORNER_YNEG[i] ? -OW'(psy_q) : OW'(psy_q);
		assign ta_y  = CORNER_XNEG[i] ? -OW'(psx_q) : OW'(psx_q);
		assign tb_y  = CORNER_YNEG[i] ? -OW'(pcy_q) : OW'(pcy_q);
		assign off_x = ta_x - tb_x + OW'(ROUND_HALF);
		assign off_y = ta_y + tb_y + OW'(ROUND_HALF);
		assign sum_x = SW'($signed(off_x[OW-1:AXIS_FRAC])) + SW'(center_x_q);
		assign sum_y = SW'($signed(off_y[OW-1:AXIS_FRAC])) + SW'(center_y_q);
		assign corner_x_d[i] = sat_c(sum_x);
		assign corner_y_d[i] = sat_c(sum_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				corner_x_q[i] <= '0;
				corner_y_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				corner_x_q[i] <= corner_x_d[i];
				corner_y_q[i] <= corner_y_d[i];
			end
		end
	end

	assign center_x = center_x_q;
	assign center_y = center_y_q;
	assign half_x   = half_x_q;
	assign half_y   = half_y_q;
	assign axis_cos = axis_cos_q;
	assign axis_sin = axis_sin_q;
	assign corner_x = corner_x_q;
	assign corner_y = corner_y_q;

endmodule

FILE: design/obt_proj.sv
module obt_proj #(
	parameter int COORD_BITS = 24
) (
	input  logic                                            clk,
	input  obt_pkg::stage_en_t                              stage_en,
	input  logic                                            command,
	input  logic signed [COORD_BITS-1:0]                    query_x,
	input  logic signed [COORD_BITS-1:0]                    query_y,
	input  logic [COORD_BITS-2:0]                           query_half_w,
	input  logic [COORD_BITS-2:0]                           query_half_h,
	input  logic signed [COORD_BITS-1:0]                    center_x,
	input  logic signed [COORD_BITS-1:0]                    center_y,
	input  logic signed [obt_pkg::AXIS_BITS-1:0]            axis_cos,
	input  logic signed [obt_pkg::AXIS_BITS-1:0]            axis_sin,
	input  logic signed [COORD_BITS-1:0]                    corner_x [4],
	input  logic signed [COORD_BITS-1:0]                    corner_y [4],
	output logic                                            cmd_s3,
	output logic signed [COORD_BITS-1:0]                    qx_s3,
	output logic signed [COORD_BITS-1:0]                    qy_s3,
	output logic                                            sepw_s3,
	output logic signed [COORD_BITS+obt_pkg::SUM_EXTRA-1:0] r_s3 [4],
	output logic signed [COORD_BITS+obt_pkg::SUM_EXTRA-1:0] u_s3 [4]
);
	import obt_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int V  = C + 2;
	localparam int P  = V + AXIS_BITS;
	localparam int S  = P + 1;
	localparam int WD = C + 1;

	// stage 1
	logic signed [V-1:0] qx_e, qy_e, cx_e, cy_e, hw_e, hh_e;
	logic signed [V-1:0] vxp_d, vxm_d, vyp_d, vym_d;
	logic                cmd_s1;
	logic signed [C-1:0] qx_s1, qy_s1;
	logic [C-2:0]        hw_s1, hh_s1;
	logic signed [V-1:0] vxp_s1, vxm_s1, vyp_s1, vym_s1;
	// stage 2
	logic signed [WD-1:0] dwx [4], dwy [4];
	logic signed [WD-1:0] hw_w, hh_w;
	logic                 sepw_d;
	logic                 cmd_s2, sepw_s2;
	logic signed [C-1:0]  qx_s2, qy_s2;
	logic signed [P-1:0]  pcxp_s2, pcxm_s2, psxp_s2, psxm_s2;
	logic signed [P-1:0]  pcyp_s2, pcym_s2, psyp_s2, psym_s2;

	function automatic logic sep_w4(input logic signed [WD-1:0] d0, d1, d2, d3, lim);
		logic pos, neg;
		pos = d0 > 0 && d1 > 0 && d2 > 0 && d3 > 0 &&
			d0 >= lim && d1 >= lim && d2 >= lim && d3 >= lim;
		neg = d0 < 0 && d1 < 0 && d2 < 0 && d3 < 0 &&
			d0 <= -lim && d1 <= -lim && d2 <= -lim && d3 <= -lim;
		return pos || neg;
	endfunction

	// stage 1: offsets; a point uses the plus/minus slots for its own offset
	assign qx_e = V'(query_x);
	assign qy_e = V'(query_y);
	assign cx_e = V'(center_x);
	assign cy_e = V'(center_y);
	assign hw_e = $signed({3'b000, query_half_w});
	assign hh_e = $signed({3'b000, query_half_h});

	assign vxp_d = (command == CMD_POINT) ? qx_e - cx_e : cx_e - qx_e + hw_e;
	assign vxm_d = cx_e - qx_e - hw_e;
	assign vyp_d = cy_e - qy_e + hh_e;
	assign vym_d = (command == CMD_POINT) ? qy_e - cy_e : cy_e - qy_e - hh_e;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			cmd_s1 <= command;
			qx_s1  <= query_x;
			qy_s1  <= query_y;
			hw_s1  <= query_half_w;
			hh_s1  <= query_half_h;
			vxp_s1 <= vxp_d;
			vxm_s1 <= vxm_d;
			vyp_s1 <= vyp_d;
			vym_s1 <= vym_d;
		end
	end

	// stage 2: world axis tests and the eight projection products
	for (genvar i = 0; i < 4; i++) begin : g_world
		assign dwx[i] = WD'(corner_x[i]) - WD'(qx_s1);
		assign dwy[i] = WD'(corner_y[i]) - WD'(qy_s1);
	end
	assign hw_w   = $signed({2'b00, hw_s1});
	assign hh_w   = $signed({2'b00, hh_s1});
	assign sepw_d = sep_w4(dwx[0], dwx[1], dwx[2], dwx[3], hw_w) ||
		sep_w4(dwy[0], dwy[1], dwy[2], dwy[3], hh_w);

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			cmd_s2  <= cmd_s1;
			qx_s2   <= qx_s1;
			qy_s2   <= qy_s1;
			sepw_s2 <= sepw_d;
			pcxp_s2 <= P'(axis_cos) * P'(vxp_s1);
			pcxm_s2 <= P'(axis_cos) * P'(vxm_s1);
			psxp_s2 <= P'(axis_sin) * P'(vxp_s1);
			psxm_s2 <= P'(axis_sin) * P'(vxm_s1);
			pcyp_s2 <= P'(axis_cos) * P'(vyp_s1);
			pcym_s2 <= P'(axis_cos) * P'(vym_s1);
			psyp_s2 <= P'(axis_sin) * P'(vyp_s1);
			psym_s2 <= P'(axis_sin) * P'(vym_s1);
		end
	end

	// stage 3: projections on the right and up axes, corner by corner
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			cmd_s3  <= cmd_s2;
			qx_s3   <= qx_s2;
			qy_s3   <= qy_s2;
			sepw_s3 <= sepw_s2;
			r_s3[0] <= S'(pcxp_s2) + S'(psym_s2);
			r_s3[1] <= S'(pcxm_s2) + S'(psym_s2);
			r_s3[2] <= S'(pcxp_s2) + S'(psyp_s2);
			r_s3[3] <= S'(pcxm_s2) + S'(psyp_s2);
			u_s3[0] <= S'(pcym_s2) - S'(psxp_s2);
			u_s3[1] <= S'(pcym_s2) - S'(psxm_s2);
			u_s3[2] <= S'(pcyp_s2) - S'(psxp_s2);
			u_s3[3] <= S'(pcyp_s2) - S'(psxm_s2);
		end
	end

endmodule

FILE: design/obt_resolve.sv
module obt_resolve #(
	parameter int COORD_BITS = 24
) (
	input  logic                                            clk,
	input  obt_pkg::stage_en_t                              stage_en,
	input  logic                                            cmd_s3,
	input  logic signed [COORD_BITS-1:0]                    qx_s3,
	input  logic signed [COORD_BITS-1:0]                    qy_s3,
	input  logic                                            sepw_s3,
	input  logic signed [COORD_BITS+obt_pkg::SUM_EXTRA-1:0] r_s3 [4],
	input  logic signed [COORD_BITS+obt_pkg::SUM_EXTRA-1:0] u_s3 [4],
	input  logic [COORD_BITS-2:0]                           half_x,
	input  logic [COORD_BITS-2:0]                           half_y,
	input  logic signed [obt_pkg::AXIS_BITS-1:0]            axis_cos,
	input  logic signed [obt_pkg::AXIS_BITS-1:0]            axis_sin,
	output logic                                            hit_s7,
	output logic signed [COORD_BITS-1:0]                    nx_s7,
	output logic signed [COORD_BITS-1:0]                    ny_s7
);
	import obt_pkg::*;

	localparam int C = COORD_BITS;
	localparam int S = C + SUM_EXTRA;
	localparam int M = S - AXIS_FRAC;
	localparam int E = M + 1;
	localparam int Q = E + AXIS_BITS;
	localparam int R = Q + 1;
	localparam int N = R - AXIS_FRAC + 1;

	// stage 4
	logic signed [S-1:0] lim_x, lim_y, abs_x, abs_y, ex_raw, ey_raw, ex_pos, ey_pos;
	logic signed [S-1:0] rnd_x, rnd_y;
	logic [M-1:0]        mag_x, mag_y;
	logic signed [E-1:0] ex_d, ey_d;
	logic                outside, sep_r, sep_u, hit_d;
	logic                hit_s4;
	logic signed [C-1:0] qx_s4, qy_s4;
	logic signed [E-1:0] ex_s4, ey_s4;
	// stage 5
	logic                hit_s5;
	logic signed [C-1:0] qx_s5, qy_s5;
	logic signed [Q-1:0] pcex_s5, psey_s5, psex_s5, pcey_s5;
	// stage 6
	logic                hit_s6;
	logic signed [C-1:0] qx_s6, qy_s6;
	logic signed [R-1:0] ox_s6, oy_s6;
	// stage 7
	logic signed [N-1:0] nxw, nyw;

	function automatic logic sep_s4(input logic signed [S-1:0] d0, d1, d2, d3, lim);
		logic pos, neg;
		pos = d0 > 0 && d1 > 0 && d2 > 0 && d3 > 0 &&
			d0 >= lim && d1 >= lim && d2 >= lim && d3 >= lim;
		neg = d0 < 0 && d1 < 0 && d2 < 0 && d3 < 0 &&
			d0 <= -lim && d1 <= -lim && d2 <= -lim && d3 <= -lim;
		return pos || neg;
	endfunction

	function automatic logic signed [C-1:0] sat_n(input logic signed [N-1:0] v);
		logic signed [C-1:0] r;
		if (v[N-1:C-1] == {(N-C+1){1'b0}} || v[N-1:C-1] == {(N-C+1){1'b1}}) begin
			r = v[C-1:0];
		end else if (v[N-1]) begin
			r = {1'b1, {(C-1){1'b0}}};
		end else begin
			r = {1'b0, {(C-1){1'b1}}};
		end
		return r;
	endfunction

	// stage 4: half extents scaled to q.14, excess past each face, box verdict
	assign lim_x = $signed({{(S-C+1-AXIS_FRAC){1'b0}}, half_x, {AXIS_FRAC{1'b0}}});
	assign lim_y = $signed({{(S-C+1-AXIS_FRAC){1'b0}}, half_y, {AXIS_FRAC{1'b0}}});

	assign abs_x  = r_s3[0][S-1] ? -r_s3[0] : r_s3[0];
	assign abs_y  = u_s3[0][S-1] ? -u_s3[0] : u_s3[0];
	assign ex_raw = abs_x - lim_x;
	assign ey_raw = abs_y - lim_y;
	assign ex_pos = ex_raw[S-1] ? '0 : ex_raw;
	assign ey_pos = ey_raw[S-1] ? '0 : ey_raw;
	assign rnd_x  = ex_pos + S'(ROUND_HALF);
	assign rnd_y  = ey_pos + S'(ROUND_HALF);
	assign mag_x  = rnd_x[S-1:AXIS_FRAC];
	assign mag_y  = rnd_y[S-1:AXIS_FRAC];
	assign outside = abs_x > lim_x || abs_y > lim_y;

	// a zero offset has zero excess, so only the negative case needs a sign
	always_comb begin
		ex_d = r_s3[0][S-1] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
		ey_d = u_s3[0][S-1] ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
		if (cmd_s3 == CMD_BOX) begin
			ex_d = '0;
			ey_d = '0;
		end
	end

	assign sep_r = sep_s4(r_s3[0], r_s3[1], r_s3[2], r_s3[3], lim_x);
	assign sep_u = sep_s4(u_s3[0], u_s3[1], u_s3[2], u_s3[3], lim_y);
	assign hit_d = (cmd_s3 == CMD_POINT) ? !outside : !(sepw_s3 || sep_r || sep_u);

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			hit_s4 <= hit_d;
			qx_s4  <= (cmd_s3 == CMD_BOX) ? '0 : qx_s3;
			qy_s4  <= (cmd_s3 == CMD_BOX) ? '0 : qy_s3;
			ex_s4  <= ex_d;
			ey_s4  <= ey_d;
		end
	end

	// stage 5: rotate the excess back to world axes
	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			hit_s5  <= hit_s4;
			qx_s5   <= qx_s4;
			qy_s5   <= qy_s4;
			pcex_s5 <= Q'(axis_cos) * Q'(ex_s4);
			psey_s5 <= Q'(axis_sin) * Q'(ey_s4);
			psex_s5 <= Q'(axis_sin) * Q'(ex_s4);
			pcey_s5 <= Q'(axis_cos) * Q'(ey_s4);
		end
	end

	// stage 6: world offset with the rounding bias added
	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			hit_s6 <= hit_s5;
			qx_s6  <= qx_s5;
			qy_s6  <= qy_s5;
			ox_s6  <= R'(pcex_s5) - R'(psey_s5) + R'(ROUND_HALF);
			oy_s6  <= R'(psex_s5) + R'(pcey_s5) + R'(ROUND_HALF);
		end
	end

	// stage 7: pull the point back onto the box and saturate
	assign nxw = N'(qx_s6) - N'($signed(ox_s6[R-1:AXIS_FRAC]));
	assign nyw = N'(qy_s6) - N'($signed(oy_s6[R-1:AXIS_FRAC]));

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			hit_s7 <= hit_s6;
			nx_s7  <= sat_n(nxw);
			ny_s7  <= sat_n(nyw);
		end
	end

endmodule

FILE: design/oriented_box_point_and_overlap_test_core.sv
// throughput: one item per cycle unless rsp back-pressure or a register write stalls;
// seven pipeline stages, each with its own valid bit, the last offering the result
// a configuration write holds req.ready low via settle_q while the corner
// products and corners are rebuilt from the new registers (two register steps)
// reset: asynchronous, active low; clears the valid bits, the settle count and the
// box registers (right axis back to +x), corners come out of reset at zero
module oriented_box_point_and_overlap_test_core #(
	parameter int COORD_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	obt_req_if.sink                            req,
	obt_rsp_if.source                          rsp,
	input  logic                               cfg_we,
	input  logic [obt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]              cfg_data
);
	import obt_pkg::*;

	localparam int C = COORD_BITS;

	// box registers and derived corners
	logic signed [C-1:0]         center_x, center_y;
	logic [C-2:0]                half_x, half_y;
	logic signed [AXIS_BITS-1:0] axis_cos, axis_sin;
	logic signed [C-1:0]         corner_x [4], corner_y [4];

	// pipeline control
	stage_en_t             stage_en;
	logic [NUM_STAGES-1:0] stage_vld_q;
	logic [1:0]            settle_q;
	logic                  accept;

	// projection half to resolve half
	logic                    cmd_s3, sepw_s3;
	logic signed [C-1:0]     qx_s3, qy_s3;
	logic signed [C+SUM_EXTRA-1:0] r_s3 [4], u_s3 [4];

	// output stage
	logic                hit_s7;
	logic signed [C-1:0] nx_s7, ny_s7;

	obt_corners #(.COORD_BITS(C)) u_corners (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.center_x  (center_x),
		.center_y  (center_y),
		.half_x    (half_x),
		.half_y    (half_y),
		.axis_cos  (axis_cos),
		.axis_sin  (axis_sin),
		.corner_x  (corner_x),
		.corner_y  (corner_y)
	);

	// stall chain: a stage may load when it is empty or the stage after it moves,
	// so bubbles close up and a stalled item stays where it is
	always_comb begin
		stage_en[NUM_STAGES-1] = !stage_vld_q[NUM_STAGES-1] || rsp.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
		end
	end

	// no item is taken until the corners reflect the latest register write
	assign req.ready = stage_en[0] && (settle_q == 2'd0);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd0;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_vld_q[0] <= accept;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	// stages 1 to 3: offsets, products, axis projections and world axis tests
	obt_proj #(.COORD_BITS(C)) u_proj (
		.clk          (clk),
		.stage_en     (stage_en),
		.command      (req.command),
		.query_x      (req.query_x),
		.query_y      (req.query_y),
		.query_half_w (req.query_half_w),
		.query_half_h (req.query_half_h),
		.center_x     (center_x),
		.center_y     (center_y),
		.axis_cos     (axis_cos),
		.axis_sin     (axis_sin),
		.corner_x     (corner_x),
		.corner_y     (corner_y),
		.cmd_s3       (cmd_s3),
		.qx_s3        (qx_s3),
		.qy_s3        (qy_s3),
		.sepw_s3      (sepw_s3),
		.r_s3         (r_s3),
		.u_s3         (u_s3)
	);

	// stages 4 to 7: verdict, clamped excess, rotation back and nearest point
	obt_resolve #(.COORD_BITS(C)) u_resolve (
		.clk      (clk),
		.stage_en (stage_en),
		.cmd_s3   (cmd_s3),
		.qx_s3    (qx_s3),
		.qy_s3    (qy_s3),
		.sepw_s3  (sepw_s3),
		.r_s3     (r_s3),
		.u_s3     (u_s3),
		.half_x   (half_x),
		.half_y   (half_y),
		.axis_cos (axis_cos),
		.axis_sin (axis_sin),
		.hit_s7   (hit_s7),
		.nx_s7    (nx_s7),
		.ny_s7    (ny_s7)
	);

	// the last stage is the output register
	assign rsp.valid     = stage_vld_q[NUM_STAGES-1];
	assign rsp.hit       = hit_s7;
	assign rsp.nearest_x = nx_s7;
	assign rsp.nearest_y = ny_s7;

	// a write always blocks the next cycle's item
	a_settle_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req.ready)
		else $error("item taken right after a register write");

	// a full pipeline that cannot drain takes nothing
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(&stage_vld_q) && !rsp.ready |-> !req.ready)
		else $error("item taken into a full stalled pipeline");

	// a held mid-pipeline item is never dropped
	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		stage_vld_q[3] && !stage_en[3] |=> stage_vld_q[3])
		else $error("stalled item lost in stage 4");

	// the stall chain never loads a stage whose successor is stuck full
	a_chain_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		stage_vld_q[0] && !stage_en[1] |-> !stage_en[0])
		else $error("stage 1 overwritten while stage 2 is stalled");

endmodule

FILE: verif/tb_oriented_box_point_and_overlap_test_core.sv
module tb_oriented_box_point_and_overlap_test_core;
	timeunit 1ns;
	timeprecision 1ps;

	import obt_pkg::*;

	localparam int COORD_BITS = 24;
	localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -(64'sd1 <<< (COORD_BITS - 1));
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 145;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int REPORT_CAP = 200;

	// register indexes past the last real register, writes to them are dropped
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-2:0] extent_t;
	typedef logic signed [AXIS_BITS-1:0] axis_t;

	typedef struct packed {
		logic    command;
		coord_t  x;
		coord_t  y;
		extent_t half_w;
		extent_t half_h;
	} query_t;

	typedef struct packed {
		logic   hit;
		coord_t nearest_x;
		coord_t nearest_y;
	} answer_t;

	// receiver stall patterns
	typedef enum int {RX_STREAM, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	// families of box settings used by the random phases
	typedef enum int {
		KIND_PLAIN, KIND_ROTATED, KIND_EXTREME_HIGH, KIND_EXTREME_LOW, KIND_WILD, KIND_LARGE
	} box_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [COORD_BITS-1:0] cfg_data;

	obt_req_if #(.COORD_BITS(COORD_BITS)) req ();
	obt_rsp_if #(.COORD_BITS(COORD_BITS)) rsp ();

	oriented_box_point_and_overlap_test_core #(.COORD_BITS(COORD_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor copy of the box: registers plus the derived corners
	// ---------------------------------------------------------------
	longint box_cx, box_cy, box_hx, box_hy, box_cos, box_sin;
	longint corner_px [4];
	longint corner_py [4];

	// items waiting to be offered, and answers waiting for their result item
	query_t  queries_to_send [$];
	answer_t pending_answers [$];

	// add one item at the tail of the send queue
	function automatic void queue_item(query_t q);
		queries_to_send.insert(queries_to_send.size(), q);
	endfunction

	// round half up out of q.14
	function automatic longint round_q14(longint v);
		return (v + longint'(ROUND_HALF)) >>> AXIS_FRAC;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	function automatic longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// all four projections strictly on one side and none closer than lim
	function automatic bit one_sided(longint d0, longint d1, longint d2, longint d3,
			longint lim);
		longint lo, hi, closest;
		lo = d0;
		hi = d0;
		closest = magnitude(d0);
		if (d1 < lo) lo = d1;
		if (d2 < lo) lo = d2;
		if (d3 < lo) lo = d3;
		if (d1 > hi) hi = d1;
		if (d2 > hi) hi = d2;
		if (d3 > hi) hi = d3;
		if (magnitude(d1) < closest) closest = magnitude(d1);
		if (magnitude(d2) < closest) closest = magnitude(d2);
		if (magnitude(d3) < closest) closest = magnitude(d3);
		return closest >= lim && ((lo > 0 && hi > 0) || (lo < 0 && hi < 0));
	endfunction

	// how far a local offset pokes past its half extent, in coordinate units
	function automatic longint local_overshoot(longint l, longint lim);
		longint e;
		e = magnitude(l) - lim;
		if (e < 0)
			e = 0;
		e = round_q14(e);
		if (l < 0)
			return -e;
		if (l > 0)
			return e;
		return 0;
	endfunction

	function automatic void rebuild_corners();
		longint a, b;
		for (int i = 0; i < 4; i++) begin
			a = CORNER_XNEG[i] ? -box_hx : box_hx;
			b = CORNER_YNEG[i] ? -box_hy : box_hy;
			corner_px[i] = clamp_coord(box_cx + round_q14(box_cos * a - box_sin * b));
			corner_py[i] = clamp_coord(box_cy + round_q14(box_sin * a + box_cos * b));
		end
	endfunction

	function automatic void reset_box_model();
		box_cx = 0;
		box_cy = 0;
		box_hx = 0;
		box_hy = 0;
		box_cos = longint'(AXIS_ONE);
		box_sin = 0;
		rebuild_corners();
	endfunction

	// mirror of one register write, upper data bits are dropped
	function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] index,
			logic [COORD_BITS-1:0] data);
		case (index)
			REG_CENTER_X: box_cx = longint'($signed(data));
			REG_CENTER_Y: box_cy = longint'($signed(data));
			REG_HALF_X:   box_hx = longint'(data[COORD_BITS-2:0]);
			REG_HALF_Y:   box_hy = longint'(data[COORD_BITS-2:0]);
			REG_AXIS_COS: box_cos = longint'($signed(data[AXIS_BITS-1:0]));
			REG_AXIS_SIN: box_sin = longint'($signed(data[AXIS_BITS-1:0]));
			default:      return;
		endcase
		rebuild_corners();
	endfunction

	// expected result of one query against the current box
	function automatic answer_t box_query_answer(query_t q);
		answer_t ans;
		longint qx, qy, hw, hh, hx14, hy14, dx, dy, lx, ly, ex, ey, vx, vy;
		longint d [4];
		bit hit;
		qx = longint'($signed(q.x));
		qy = longint'($signed(q.y));
		hw = longint'(q.half_w);
		hh = longint'(q.half_h);
		hx14 = box_hx <<< AXIS_FRAC;
		hy14 = box_hy <<< AXIS_FRAC;
		ans.nearest_x = '0;
		ans.nearest_y = '0;
		if (q.command == CMD_POINT) begin
			dx = qx - box_cx;
			dy = qy - box_cy;
			lx = box_cos * dx + box_sin * dy;
			ly = -box_sin * dx + box_cos * dy;
			if (magnitude(lx) > hx14 || magnitude(ly) > hy14) begin
				ex = local_overshoot(lx, hx14);
				ey = local_overshoot(ly, hy14);
				ans.nearest_x = coord_t'(clamp_coord(qx - round_q14(box_cos * ex - box_sin * ey)));
				ans.nearest_y = coord_t'(clamp_coord(qy - round_q14(box_sin * ex + box_cos * ey)));
				hit = 1'b0;
			end else begin
				ans.nearest_x = q.x;
				ans.nearest_y = q.y;
				hit = 1'b1;
			end
		end else begin
			hit = 1'b1;
			// world x, then world y against the stored corners
			for (int i = 0; i < 4; i++)
				d[i] = corner_px[i] - qx;
			if (one_sided(d[0], d[1], d[2], d[3], hw))
				hit = 1'b0;
			for (int i = 0; i < 4; i++)
				d[i] = corner_py[i] - qy;
			if (hit && one_sided(d[0], d[1], d[2], d[3], hh))
				hit = 1'b0;
			// right axis, then up axis against the aligned box corners
			if (hit) begin
				for (int i = 0; i < 4; i++) begin
					vx = box_cx - (qx + (CORNER_XNEG[i] ? -hw : hw));
					vy = box_cy - (qy + (CORNER_YNEG[i] ? -hh : hh));
					d[i] = box_cos * vx + box_sin * vy;
				end
				if (one_sided(d[0], d[1], d[2], d[3], hx14))
					hit = 1'b0;
			end
			if (hit) begin
				for (int i = 0; i < 4; i++) begin
					vx = box_cx - (qx + (CORNER_XNEG[i] ? -hw : hw));
					vy = box_cy - (qy + (CORNER_YNEG[i] ? -hh : hh));
					d[i] = -box_sin * vx + box_cos * vy;
				end
				if (one_sided(d[0], d[1], d[2], d[3], hy14))
					hit = 1'b0;
			end
		end
		ans.hit = hit;
		return ans;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	function automatic query_t make_query(logic cmd, longint x, longint y, longint hw,
			longint hh);
		query_t q;
		q.command = cmd;
		q.x = coord_t'(x);
		q.y = coord_t'(y);
		q.half_w = extent_t'(hw);
		q.half_h = extent_t'(hh);
		return q;
	endfunction

	// place a query at local offsets (a along right, b along up) from the box centre
	function automatic query_t at_local(logic cmd, longint a, longint b, longint hw,
			longint hh);
		return make_query(cmd, box_cx + ((box_cos * a - box_sin * b) >>> AXIS_FRAC),
			box_cy + ((box_sin * a + box_cos * b) >>> AXIS_FRAC), hw, hh);
	endfunction

	// mostly queries around the box so both outcomes turn up, some pure noise
	function automatic query_t random_query();
		query_t q;
		longint span;
		int pick;
		span = box_hx + box_hy + 512;
		if (span > 64'sd33554432)
			span = 64'sd33554432;
		pick = $urandom_range(0, 99);
		q.command = (pick >= 45) ? CMD_BOX : CMD_POINT;
		q.x = coord_t'(box_cx + longint'($urandom_range(0, 32'(2 * span))) - span);
		q.y = coord_t'(box_cy + longint'($urandom_range(0, 32'(2 * span))) - span);
		q.half_w = extent_t'($urandom);
		q.half_h = extent_t'($urandom);
		if (q.command == CMD_BOX) begin
			if ($urandom_range(0, 2) == 0) begin
				q.half_w = extent_t'($urandom_range(0, 64));
				q.half_h = extent_t'($urandom_range(0, 64));
			end else begin
				q.half_w = extent_t'($urandom_range(0, 32'(span)));
				q.half_h = extent_t'($urandom_range(0, 32'(span)));
			end
		end
		if (pick >= 85) begin
			q.command = $urandom_range(0, 1) ? CMD_BOX : CMD_POINT;
			q.x = coord_t'($urandom);
			q.y = coord_t'($urandom);
		end
		return q;
	endfunction

	function automatic void pick_unit_axis(output axis_t c, output axis_t s);
		case ($urandom_range(0, 7))
			0: begin c = 16'sd16384;  s = 16'sd0;      end
			1: begin c = 16'sd0;      s = 16'sd16384;  end
			2: begin c = -16'sd16384; s = 16'sd0;      end
			3: begin c = 16'sd0;      s = -16'sd16384; end
			4: begin c = 16'sd11585;  s = 16'sd11585;  end
			5: begin c = -16'sd11585; s = 16'sd11585;  end
			6: begin c = 16'sd14189;  s = -16'sd8192;  end
			default: begin c = -16'sd15137; s = -16'sd6270; end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// sender: bursts of random length with random gaps in between
	// ---------------------------------------------------------------
	bit req_fire;
	bit sender_gaps;
	int burst_left;
	int gap_left;
	query_t offered;

	always @(negedge clk) begin
		// an item still waiting for ready stays on the bus untouched
		if (!(req.valid && !req_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				req.valid <= 1'b0;
			end else if (queries_to_send.size() == 0) begin
				req.valid <= 1'b0;
			end else begin
				offered = queries_to_send.pop_front();
				req.command <= offered.command;
				req.query_x <= offered.x;
				req.query_y <= offered.y;
				req.query_half_w <= offered.half_w;
				req.query_half_h <= offered.half_h;
				req.valid <= 1'b1;
				if (sender_gaps) begin
					if (burst_left == 0)
						burst_left = $urandom_range(1, 32);
					burst_left--;
					if (burst_left == 0)
						gap_left = $urandom_range(1, 8);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: its own stall pattern, plus a long hold-off on request
	// ---------------------------------------------------------------
	int hold_requests;
	int hold_served;
	int hold_left;
	rx_mode_t rx_mode;
	int rx_mode_left;
	int rx_period;
	int rx_tick;

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			// long stretch of back-pressure, pipeline fills and input stalls
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(50, 300);
				rx_period = $urandom_range(2, 5);
			end
			rx_mode_left--;
			rx_tick++;
			case (rx_mode)
				RX_STREAM:   rsp.ready <= 1'b1;
				RX_RANDOM:   rsp.ready <= ($urandom_range(0, 9) < 7);
				RX_PERIODIC: rsp.ready <= (rx_tick % rx_period) != 0;
				default:     rsp.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// monitor: predicts on every accepted query, checks every result item
	// ---------------------------------------------------------------
	int mismatches;
	int cycle_count;
	int point_items;
	int box_items;
	int hit_count;
	int settings_used;
	query_t seen_query;
	answer_t want;

	task automatic note_mismatch(string what, longint expected_value, longint actual_value);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("%0t ns: %s expected %0d actual %0d", $time, what, expected_value,
				actual_value);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("oriented_box_point_and_overlap_test_core regression: fail");
			$finish;
		end else begin
			req_fire = req.valid && req.ready;
			if (arst_n && req_fire) begin
				seen_query.command = req.command;
				seen_query.x = req.query_x;
				seen_query.y = req.query_y;
				seen_query.half_w = req.query_half_w;
				seen_query.half_h = req.query_half_h;
				pending_answers.insert(pending_answers.size(), box_query_answer(seen_query));
				if (seen_query.command == CMD_POINT)
					point_items++;
				else
					box_items++;
			end
			if (arst_n && rsp.valid && rsp.ready) begin
				if (pending_answers.size() == 0) begin
					note_mismatch("result item with nothing outstanding, hit", -1, rsp.hit);
				end else begin
					want = pending_answers.pop_front();
					if (want.hit)
						hit_count++;
					if (rsp.hit !== want.hit)
						note_mismatch("hit", want.hit, rsp.hit);
					if (rsp.nearest_x !== want.nearest_x)
						note_mismatch("nearest_x", want.nearest_x, rsp.nearest_x);
					if (rsp.nearest_y !== want.nearest_y)
						note_mismatch("nearest_y", want.nearest_y, rsp.nearest_y);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// configuration and phase control
	// ---------------------------------------------------------------

	// wait until every offered item has been answered, then let the pipe settle
	task automatic drain();
		while (queries_to_send.size() != 0 || req.valid || pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [COORD_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		apply_reg(index, data);
	endtask

	task automatic program_box(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
			logic [COORD_BITS-1:0] hx, logic [COORD_BITS-1:0] hy,
			logic [COORD_BITS-1:0] c, logic [COORD_BITS-1:0] s, bit with_spare);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_HALF_X, hx);
		write_reg(REG_HALF_Y, hy);
		write_reg(REG_AXIS_COS, c);
		write_reg(REG_AXIS_SIN, s);
		// a write past the last register must leave the box alone
		if (with_spare)
			write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
				logic'($urandom) ? COORD_BITS'($urandom) : '1);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic configure_box(box_kind_t kind);
		coord_t cx, cy;
		extent_t hx, hy;
		axis_t c, s;
		logic [31:0] junk;
		cx = coord_t'($urandom_range(0, 2097152)) - 24'sd1048576;
		cy = coord_t'($urandom_range(0, 2097152)) - 24'sd1048576;
		hx = extent_t'($urandom_range(0, 20000));
		hy = extent_t'($urandom_range(0, 20000));
		c = AXIS_ONE;
		s = '0;
		case (kind)
			KIND_ROTATED: pick_unit_axis(c, s);
			KIND_EXTREME_HIGH: begin
				// top corner of the coordinate range, corners saturate
				cx = coord_t'(COORD_MAX);
				cy = coord_t'(COORD_MAX);
				hx = '1;
				hy = '1;
				c = $urandom_range(0, 1) ? -AXIS_ONE : AXIS_ONE;
				s = $urandom_range(0, 1) ? -AXIS_ONE : AXIS_ONE;
			end
			KIND_EXTREME_LOW: begin
				// degenerate box at the bottom of the range
				cx = coord_t'(COORD_MIN);
				cy = coord_t'(COORD_MIN);
				hx = '0;
				hy = '0;
				c = '0;
				s = -AXIS_ONE;
			end
			KIND_WILD: begin
				// anything goes, including axes that are not unit length
				cx = coord_t'($urandom);
				cy = coord_t'($urandom);
				hx = extent_t'($urandom);
				hy = extent_t'($urandom);
				c = axis_t'($urandom);
				s = axis_t'($urandom);
			end
			KIND_LARGE: begin
				cx = coord_t'($urandom);
				cy = coord_t'($urandom);
				hx = extent_t'($urandom);
				hy = extent_t'($urandom);
				pick_unit_axis(c, s);
			end
			default: ;
		endcase
		junk = $urandom;
		// unused upper data bits carry noise
		program_box(cx, cy, {junk[0], hx}, {junk[1], hy}, {junk[15:8], c}, {junk[23:16], s},
			junk[31]);
	endtask

	initial begin
		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.command = CMD_POINT;
		req.query_x = '0;
		req.query_y = '0;
		req.query_half_w = '0;
		req.query_half_h = '0;
		rsp.ready = 1'b0;
		sender_gaps = 1'b0;
		reset_box_model();

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// box straight out of reset: zero size at the origin, so only its centre is inside
		queue_item(make_query(CMD_POINT, 0, 0, 0, 0));
		queue_item(make_query(CMD_POINT, 1, -1, 0, 0));
		queue_item(make_query(CMD_BOX, 0, 0, 0, 0));
		// touching along world x counts as apart
		queue_item(make_query(CMD_BOX, 300, 0, 300, 300));
		drain();

		// directed set against a box turned by thirty degrees
		program_box(24'sd4096, -24'sd2560, 24'd1280, 24'd768, 24'(16'sd14189),
			24'(16'sd8192), 1'b0);
		// zero local offset on both axes
		queue_item(at_local(CMD_POINT, 0, 0, 0, 0));
		// just past each face, off a corner, and inside at half extents
		queue_item(at_local(CMD_POINT, box_hx + 200, 0, 0, 0));
		queue_item(at_local(CMD_POINT, -(box_hx + 200), 0, 0, 0));
		queue_item(at_local(CMD_POINT, 0, box_hy + 150, 0, 0));
		queue_item(at_local(CMD_POINT, 0, -(box_hy + 150), 0, 0));
		queue_item(at_local(CMD_POINT, box_hx + 500, -(box_hy + 500), 0, 0));
		queue_item(at_local(CMD_POINT, box_hx / 2, box_hy / 2, 0, 0));
		// aligned boxes: centred, clear on world x, clear on world y, off each box axis
		queue_item(at_local(CMD_BOX, 0, 0, 100, 100));
		queue_item(make_query(CMD_BOX, box_cx + 5000, box_cy, 100, 100));
		queue_item(make_query(CMD_BOX, box_cx, box_cy - 5000, 100, 100));
		queue_item(at_local(CMD_BOX, box_hx + box_hy + 800, 0, 60, 60));
		queue_item(at_local(CMD_BOX, 0, box_hy + 2000, 40, 40));
		// field extremes, half sizes of a point query are don't-care
		queue_item(make_query(CMD_BOX, COORD_MAX, COORD_MIN, '1, '1));
		queue_item(make_query(CMD_BOX, COORD_MIN, COORD_MAX, 0, 0));
		queue_item(make_query(CMD_POINT, COORD_MIN, COORD_MAX, '1, '1));
		queue_item(make_query(CMD_POINT, COORD_MAX, COORD_MAX, 0, 0));
		drain();

		// random phases, each with a fresh box setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			configure_box(box_kind_t'(phase % 6));
			sender_gaps = ($urandom_range(0, 3) != 0);
			if (phase == 1 || phase == 7)
				sender_gaps = 1'b0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				queue_item(random_query());
			// receiver holds off while the sender keeps offering
			if (phase == 1 || phase == 7)
				hold_requests++;
			drain();
		end

		$display("covered %0d point queries and %0d aligned box queries, %0d of them hits",
			point_items, box_items, hit_count);
		$display("across %0d box settings, from degenerate to saturating, with stalls",
			settings_used);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("oriented_box_point_and_overlap_test_core regression: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("oriented_box_point_and_overlap_test_core regression: fail");
		end
		$finish;
	end

endmodule
